@@ hw/rtl/vog_pkg.sv @@
`timescale 1ns / 1ps
// Package for the voxel occupancy grid unit.
// Holds field widths, command, code and register index constants.
package vog_pkg;

  localparam int CMD_W      = 2;
  localparam int CODE_W     = 2;
  localparam int POS_W      = 32;
  localparam int VSIZE_W    = 16;
  localparam int EXT_XY_W   = 7;
  localparam int EXT_Z_W    = 5;
  localparam int IDX_XY_W   = 6;
  localparam int IDX_Z_W    = 4;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Offset magnitude times two plus voxel size, and twice the voxel size.
  localparam int NUM_W = 35;
  localparam int DIV_W = VSIZE_W + 1;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [CODE_W-1:0]    code_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam cmd_t CMD_READ_POS  = 2'd0;
  localparam cmd_t CMD_WRITE_POS = 2'd1;
  localparam cmd_t CMD_READ_IDX  = 2'd2;

  localparam code_t OCC_OOB      = 2'd0;
  localparam code_t OCC_UNMAPPED = 2'd1;

  localparam reg_idx_t REG_ORIGIN_X   = 3'd0;
  localparam reg_idx_t REG_ORIGIN_Y   = 3'd1;
  localparam reg_idx_t REG_ORIGIN_Z   = 3'd2;
  localparam reg_idx_t REG_VOXEL_SIZE = 3'd3;
  localparam reg_idx_t REG_EXTENT_X   = 3'd4;
  localparam reg_idx_t REG_EXTENT_Y   = 3'd5;
  localparam reg_idx_t REG_EXTENT_Z   = 3'd6;

  localparam logic [VSIZE_W-1:0]  VSIZE_RESET    = 16'd16;
  localparam logic [EXT_XY_W-1:0] EXTENT_X_RESET = 7'd64;
  localparam logic [EXT_XY_W-1:0] EXTENT_Y_RESET = 7'd64;
  localparam logic [EXT_Z_W-1:0]  EXTENT_Z_RESET = 5'd16;

endpackage

@@ hw/rtl/vog_cmd_if.sv @@
`timescale 1ns / 1ps
// Command channel of the voxel occupancy grid unit.
// Depends on vog_pkg for field widths.
interface vog_cmd_if import vog_pkg::*; ();
  logic                       valid;
  logic                       ready;
  cmd_t                       command;
  logic signed [POS_W-1:0]    pos_x;
  logic signed [POS_W-1:0]    pos_y;
  logic signed [POS_W-1:0]    pos_z;
  logic        [IDX_XY_W-1:0] index_x;
  logic        [IDX_XY_W-1:0] index_y;
  logic        [IDX_Z_W-1:0]  index_z;
  code_t                      write_code;

  modport source (output valid, command, pos_x, pos_y, pos_z, index_x, index_y, index_z,
                  write_code, input ready);
  modport sink (input valid, command, pos_x, pos_y, pos_z, index_x, index_y, index_z,
                write_code, output ready);
endinterface

@@ hw/rtl/vog_res_if.sv @@
`timescale 1ns / 1ps
// Result channel of the voxel occupancy grid unit.
// Depends on vog_pkg for the code type.
interface vog_res_if import vog_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t occupancy;
  logic  accepted;

  modport source (output valid, occupancy, accepted, input ready);
  modport sink (input valid, occupancy, accepted, output ready);
endinterface

@@ hw/rtl/vog_cfg_if.sv @@
`timescale 1ns / 1ps
// Register write channel of the voxel occupancy grid unit.
// Depends on vog_pkg for index and data widths.
interface vog_cfg_if import vog_pkg::*; ();
  logic                  valid;
  logic                  ready;
  reg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/voxel_occupancy_grid_unit.sv @@
`timescale 1ns / 1ps
// Voxel occupancy grid unit: 2-bit codes in one single-port memory with a registered read.
// Position reads: difference, normalise, range check, then a divider retiring one quotient
// bit per cycle per axis over CW bits (CW = max index width, at least 6; 6 by default),
// address, memory access and read; writes skip the read, positions off the grid go from
// the check to the result. Index reads go straight to the address step, out-of-range ones
// to the result; one item at a time. Reset: a clearing pass writes unmapped to all entries.
module voxel_occupancy_grid_unit import vog_pkg::*; #(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64,
  parameter int MAX_Z = 16
) (
  input  logic      clk,
  input  logic      rst,
  vog_cmd_if.sink   cmd,
  vog_res_if.source res,
  vog_cfg_if.sink   cfg
);

  localparam int XW  = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int YW  = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int ZW  = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int CW0 = (XW > YW) ? XW : YW;
  localparam int CW1 = (CW0 > ZW) ? CW0 : ZW;
  localparam int CW  = (CW1 > IDX_XY_W) ? CW1 : IDX_XY_W;
  localparam int EW  = (CW + 1 > EXT_XY_W) ? CW + 1 : EXT_XY_W;
  localparam int SW  = $clog2(CW);
  localparam int PW  = DIV_W + EW;
  localparam int DEPTH    = MAX_X * MAX_Y * MAX_Z;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STRIDE_Z = MAX_X * MAX_Y;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIFF  = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_ADDR  = 4'd6;
  localparam logic [3:0] S_MEM   = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  logic [AW-1:0] clr_cnt;

  logic [POS_W-1:0]   org_x, org_y, org_z;
  logic [VSIZE_W-1:0] vsize;
  logic [EXT_XY_W-1:0] ext_x, ext_y;
  logic [EXT_Z_W-1:0]  ext_z;

  logic [POS_W-1:0] org [3];
  logic [EW-1:0]    lim [3];
  logic [NUM_W-1:0] dvs;
  logic [NUM_W-1:0] dsh;

  cmd_t             cmd_r;
  code_t            wcode;
  logic [POS_W-1:0] pos [3];
  logic [POS_W:0]   diff [3];
  logic [PW-1:0]    prod [3];
  logic [NUM_W-1:0] num [3];
  logic             neg [3];
  logic [CW-1:0]    quo [3];
  logic [SW-1:0]    step;
  logic             in_grid;
  logic             in_ax [3];
  logic             idx_in;
  logic [AW-1:0]    addr;
  code_t            occ_r;

  logic          res_valid;
  code_t         res_occ;
  logic          res_acc;

  code_t         mem [DEPTH];
  code_t         mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  code_t         mem_wdata;

  always_comb begin
    org[0] = org_x;
    org[1] = org_y;
    org[2] = org_z;
    lim[0] = (EW'(ext_x) > EW'(MAX_X)) ? EW'(MAX_X) : EW'(ext_x);
    lim[1] = (EW'(ext_y) > EW'(MAX_Y)) ? EW'(MAX_Y) : EW'(ext_y);
    lim[2] = (EW'(ext_z) > EW'(MAX_Z)) ? EW'(MAX_Z) : EW'(ext_z);
    dvs = NUM_W'({vsize, 1'b0});
    dsh = dvs << step;
    for (int i = 0; i < 3; i++) begin
      in_ax[i] = (vsize != '0) && (num[i] < NUM_W'(prod[i])) && (!neg[i] || num[i] < dvs);
    end
    idx_in = (EW'(cmd.index_x) < lim[0]) && (EW'(cmd.index_y) < lim[1]) &&
             (EW'(cmd.index_z) < lim[2]);
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      org_x <= '0;
      org_y <= '0;
      org_z <= '0;
      vsize <= VSIZE_RESET;
      ext_x <= EXTENT_X_RESET;
      ext_y <= EXTENT_Y_RESET;
      ext_z <= EXTENT_Z_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ORIGIN_X:   org_x <= cfg.data;
        REG_ORIGIN_Y:   org_y <= cfg.data;
        REG_ORIGIN_Z:   org_z <= cfg.data;
        REG_VOXEL_SIZE: vsize <= cfg.data[VSIZE_W-1:0];
        REG_EXTENT_X:   ext_x <= cfg.data[EXT_XY_W-1:0];
        REG_EXTENT_Y:   ext_y <= cfg.data[EXT_XY_W-1:0];
        REG_EXTENT_Z:   ext_z <= cfg.data[EXT_Z_W-1:0];
        default: ;
      endcase
    end
  end

  assign cmd.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_r  <= cmd.command;
            wcode  <= cmd.write_code;
            pos[0] <= cmd.pos_x;
            pos[1] <= cmd.pos_y;
            pos[2] <= cmd.pos_z;
            quo[0] <= CW'(cmd.index_x);
            quo[1] <= CW'(cmd.index_y);
            quo[2] <= CW'(cmd.index_z);
            occ_r  <= OCC_OOB;
            case (cmd.command)
              CMD_READ_POS, CMD_WRITE_POS: begin
                state <= S_DIFF;
              end
              CMD_READ_IDX: begin
                in_grid <= idx_in;
                state   <= idx_in ? S_ADDR : S_DONE;
              end
              default: begin
                in_grid <= 1'b0;
                state   <= S_DONE;
              end
            endcase
          end
        end
        S_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            diff[i] <= {pos[i][POS_W-1], pos[i]} - {org[i][POS_W-1], org[i]};
            prod[i] <= PW'(lim[i]) * PW'({vsize, 1'b0});
          end
          state <= S_NORM;
        end
        S_NORM: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= diff[i][POS_W];
            if (diff[i][POS_W]) begin
              num[i] <= NUM_W'({~diff[i], 1'b0}) + NUM_W'(vsize) + NUM_W'(2);
            end else begin
              num[i] <= NUM_W'({diff[i], 1'b0}) + NUM_W'(vsize);
            end
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          in_grid <= in_ax[0] && in_ax[1] && in_ax[2];
          for (int i = 0; i < 3; i++) begin
            quo[i] <= '0;
          end
          step  <= SW'(CW - 1);
          state <= (in_ax[0] && in_ax[1] && in_ax[2]) ? S_DIV : S_DONE;
        end
        S_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (num[i] >= dsh) begin
              num[i]       <= num[i] - dsh;
              quo[i][step] <= 1'b1;
            end
          end
          step <= step - 1'b1;
          if (step == '0) begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          addr  <= AW'(quo[2]) * AW'(STRIDE_Z) + AW'(quo[1]) * AW'(MAX_X) + AW'(quo[0]);
          state <= S_MEM;
        end
        S_MEM: begin
          state <= (cmd_r == CMD_WRITE_POS) ? S_DONE : S_RD;
        end
        S_RD: begin
          occ_r <= mem_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            res_occ   <= occ_r;
            res_acc   <= in_grid;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign mem_we    = (state == S_CLEAR) || (state == S_MEM && cmd_r == CMD_WRITE_POS);
  assign mem_addr  = (state == S_CLEAR) ? clr_cnt : addr;
  assign mem_wdata = (state == S_CLEAR) ? OCC_UNMAPPED : wcode;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  assign res.valid     = res_valid;
  assign res.occupancy = res_occ;
  assign res.accepted  = res_acc;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> (state != S_IDLE))
    else $error("item accepted but control stayed idle");

  a_oob_code: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.accepted) |-> (res.occupancy == OCC_OOB))
    else $error("rejected item carries a nonzero code");

  a_write_inside: assert property (@(posedge clk) disable iff (rst)
    (state == S_MEM && cmd_r == CMD_WRITE_POS) |-> in_grid)
    else $error("memory write for a voxel outside the grid");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !res.valid)
    else $error("result presented during the clearing pass");

endmodule
